// ===== rtl/core/fcr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcr_pkg
// shared types and codes for the cluster chain file read core
// ----------------------------------------------------------------------------
package fcr_pkg;

    localparam int LINK_AW_MAX = 16;
    localparam int DATA_AW_MAX = 24;

    typedef enum logic [1:0] {
        OP_LINK_WR = 2'd0,
        OP_DATA_WR = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } fcr_op_t;

    localparam logic [1:0] REG_CLUSTER_SIZE = 2'd0;
    localparam logic [1:0] REG_EMPTY_MARKER = 2'd1;
    localparam logic [1:0] REG_END_MARKER   = 2'd2;

    // write and read requests toward the link and data memories
    typedef struct packed {
        logic                   link_we;
        logic [LINK_AW_MAX-1:0] link_waddr;
        logic [15:0]            link_wdata;
        logic                   data_we;
        logic [DATA_AW_MAX-1:0] data_waddr;
        logic [7:0]             data_wdata;
        logic                   link_re;
        logic [LINK_AW_MAX-1:0] link_raddr;
        logic                   data_re;
        logic [DATA_AW_MAX-1:0] data_raddr;
    } fcr_mem_req_t;

endpackage

// ===== rtl/core/fcr_div.sv =====
// ----------------------------------------------------------------------------
// fcr_div
// restoring divider, one quotient bit per cycle, 16 by 13 bits
// ----------------------------------------------------------------------------
module fcr_div
    import fcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [12:0] divisor,
    output logic        done,
    output logic [15:0] quot,
    output logic [12:0] rem
);

    logic [15:0] quot_reg, quot_next;
    logic [13:0] rem_reg, rem_next;
    logic [12:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [13:0] trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[12:0], quot_reg[15]};
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[14:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg[12:0];

endmodule

// ===== rtl/core/fcr_store.sv =====
// ----------------------------------------------------------------------------
// fcr_store
// link table and cluster data memories, reads registered and ready in the next cycle
// ----------------------------------------------------------------------------
module fcr_store
    import fcr_pkg::*;
#(
    parameter int LINK_ENTRIES = 1024,
    parameter int DATA_BYTES   = 65536
)
(
    input  logic         aclk,
    input  fcr_mem_req_t req,
    output logic [15:0]  link_rdata,
    output logic [7:0]   data_rdata
);

    localparam int LW = (LINK_ENTRIES > 1) ? $clog2(LINK_ENTRIES) : 1;
    localparam int DW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

    logic [15:0] link_mem [LINK_ENTRIES];
    logic [7:0]  data_mem [DATA_BYTES];
    logic [15:0] link_rdata_reg;
    logic [7:0]  data_rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.link_we) begin
            link_mem[req.link_waddr[LW-1:0]] <= req.link_wdata;
        end
        if (req.link_re) begin
            link_rdata_reg <= link_mem[req.link_raddr[LW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.data_we) begin
            data_mem[req.data_waddr[DW-1:0]] <= req.data_wdata;
        end
        if (req.data_re) begin
            data_rdata_reg <= data_mem[req.data_raddr[DW-1:0]];
        end
    end

    assign link_rdata = link_rdata_reg;
    assign data_rdata = data_rdata_reg;

endmodule

// ===== rtl/core/fat_chain_file_read_core.sv =====
// ----------------------------------------------------------------------------
// fat_chain_file_read_core
// file read over a linked cluster chain held in on-chip memories
// ----------------------------------------------------------------------------
// channel  dir  handshake             contents
// s_       in   s_tvalid/s_tready     link write, data write or read request
// m_       out  m_tvalid/m_tready     file byte or end/error marker
// cfg_     in   cfg_valid/cfg_ready   cluster size, empty and end markers
//
// writes go straight to the memories; the block is ready again the next cycle.
// a read divides the offset, walks the link hops, then per byte forms, checks and reads
// its address, plus a link read per cluster crossing, each memory via one read port.
// aresetn is synchronous; the memories are not cleared.
// a stalled m_ holds the sequencer in place; s_ is ready only between reads.
// ----------------------------------------------------------------------------
module fat_chain_file_read_core
    import fcr_pkg::*;
#(
    parameter int LINK_ENTRIES = 1024,
    parameter int DATA_BYTES   = 65536,
    parameter int MAX_READ     = 64
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // link_index, link_value, data_address, data_value, start_cluster,
    // read_position, byte_count, file_size
    input  logic [103:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_byte
    output logic [7:0]   m_tdata,
    // has_byte, chain_error
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_DIV      = 10'b0000000010,
        ST_HOP      = 10'b0000000100,
        ST_HOP_CHK  = 10'b0000001000,
        ST_ADDR     = 10'b0000010000,
        ST_DCHK     = 10'b0000100000,
        ST_DOUT     = 10'b0001000000,
        ST_LINK     = 10'b0010000000,
        ST_LINK_CHK = 10'b0100000000,
        ST_END      = 10'b1000000000
    } state_t;

    // unpack request fields
    logic [9:0]  link_index;
    logic [15:0] link_value, data_address, read_position, file_size;
    logic [7:0]  data_value;
    logic [9:0]  start_cluster;
    logic [6:0]  byte_count;
    fcr_op_t     operation;

    assign link_index    = s_tdata[9:0];
    assign link_value    = s_tdata[25:10];
    assign data_address  = s_tdata[41:26];
    assign data_value    = s_tdata[49:42];
    assign start_cluster = s_tdata[59:50];
    assign read_position = s_tdata[75:60];
    assign byte_count    = s_tdata[82:76];
    assign file_size     = s_tdata[98:83];
    assign operation     = fcr_op_t'(s_tuser);

    // configuration
    logic [12:0] cluster_size_reg;
    logic [15:0] empty_marker_reg, end_marker_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_size_reg <= 13'd512;
            empty_marker_reg <= 16'd0;
            end_marker_reg   <= 16'hFFFF;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CLUSTER_SIZE: cluster_size_reg <= cfg_data[12:0];
                REG_EMPTY_MARKER: empty_marker_reg <= cfg_data;
                REG_END_MARKER:   end_marker_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t      state_reg, state_next;
    logic [15:0] cl_reg, cl_next;
    logic [12:0] cs_reg, cs_next;
    logic [12:0] off_reg, off_next;
    logic [15:0] hops_reg, hops_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [29:0] addr_reg, addr_next;
    logic        err_reg, err_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_has_reg, out_has_next;
    logic        out_last_reg, out_last_next;
    logic        out_err_reg, out_err_next;

    logic         accept, out_free, load_out, div_start, div_done;
    logic [15:0]  div_quot;
    logic [12:0]  div_rem;
    logic [15:0]  link_rdata;
    logic [7:0]   data_rdata;
    fcr_mem_req_t mem_req;
    logic [6:0]   cnt_clamp, cnt_init;
    logic [16:0]  pos_end;
    logic [12:0]  cs_init;
    logic         cl_in_range, link_bad;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // zero cluster size acts as one byte
    assign cs_init = (cluster_size_reg == '0) ? 13'd1 : cluster_size_reg;

    assign cnt_clamp = (byte_count > 7'(MAX_READ)) ? 7'(MAX_READ) : byte_count;
    assign pos_end   = {1'b0, read_position} + 17'(cnt_clamp);
    always_comb begin
        if (read_position >= file_size) begin
            cnt_init = '0;
        end else if (pos_end > {1'b0, file_size}) begin
            cnt_init = 7'(file_size - read_position);
        end else begin
            cnt_init = cnt_clamp;
        end
    end

    assign cl_in_range = ({1'b0, cl_reg} < 17'(LINK_ENTRIES));
    assign link_bad    = (link_rdata == empty_marker_reg) || (link_rdata == end_marker_reg);

    always_comb begin
        state_next     = state_reg;
        cl_next        = cl_reg;
        cs_next        = cs_reg;
        off_next       = off_reg;
        hops_next      = hops_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        err_next       = err_reg;
        div_start      = 1'b0;
        load_out       = 1'b0;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        mem_req        = '0;
        mem_req.link_waddr = LINK_AW_MAX'(link_index);
        mem_req.link_wdata = link_value;
        mem_req.data_waddr = DATA_AW_MAX'(data_address);
        mem_req.data_wdata = data_value;
        mem_req.link_raddr = cl_reg;
        mem_req.data_raddr = DATA_AW_MAX'(addr_reg);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (operation)
                        OP_LINK_WR: begin
                            mem_req.link_we = (17'(link_index) < 17'(LINK_ENTRIES));
                        end
                        OP_DATA_WR: begin
                            mem_req.data_we = (25'(data_address) < 25'(DATA_BYTES));
                        end
                        OP_READ: begin
                            cl_next  = 16'(start_cluster);
                            cs_next  = cs_init;
                            cnt_next = cnt_init;
                            if (cnt_init == '0) begin
                                err_next   = 1'b0;
                                state_next = ST_END;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    hops_next  = div_quot;
                    off_next   = div_rem;
                    state_next = ST_HOP;
                end
            end
            ST_HOP: begin
                if (hops_reg == '0) begin
                    state_next = ST_ADDR;
                end else if (!cl_in_range) begin
                    err_next   = 1'b1;
                    state_next = ST_END;
                end else begin
                    mem_req.link_re = 1'b1;
                    state_next      = ST_HOP_CHK;
                end
            end
            ST_HOP_CHK: begin
                if (link_bad) begin
                    err_next   = 1'b1;
                    state_next = ST_END;
                end else begin
                    cl_next    = link_rdata;
                    hops_next  = hops_reg - 16'd1;
                    state_next = ST_HOP;
                end
            end
            ST_ADDR: begin
                addr_next  = 30'(cl_reg) * 30'(cs_reg) + 30'(off_reg);
                state_next = ST_DCHK;
            end
            ST_DCHK: begin
                if (addr_reg >= 30'(DATA_BYTES)) begin
                    err_next   = 1'b1;
                    state_next = ST_END;
                end else begin
                    mem_req.data_re = 1'b1;
                    state_next      = ST_DOUT;
                end
            end
            ST_DOUT: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_byte_next = data_rdata;
                    out_has_next  = 1'b1;
                    out_last_next = (cnt_reg == 7'd1);
                    out_err_next  = 1'b0;
                    cnt_next      = cnt_reg - 7'd1;
                    off_next      = off_reg + 13'd1;
                    if (cnt_reg == 7'd1) begin
                        state_next = ST_IDLE;
                    end else if ({1'b0, off_reg} + 14'd1 == {1'b0, cs_reg}) begin
                        state_next = ST_LINK;
                    end else begin
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_LINK: begin
                if (!cl_in_range) begin
                    err_next   = 1'b1;
                    state_next = ST_END;
                end else begin
                    mem_req.link_re = 1'b1;
                    state_next      = ST_LINK_CHK;
                end
            end
            ST_LINK_CHK: begin
                if (link_bad) begin
                    err_next   = 1'b1;
                    state_next = ST_END;
                end else begin
                    cl_next    = link_rdata;
                    off_next   = '0;
                    state_next = ST_ADDR;
                end
            end
            ST_END: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_byte_next = '0;
                    out_has_next  = 1'b0;
                    out_last_next = 1'b1;
                    out_err_next  = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        cl_reg       <= cl_next;
        cs_reg       <= cs_next;
        off_reg      <= off_next;
        hops_reg     <= hops_next;
        cnt_reg      <= cnt_next;
        addr_reg     <= addr_next;
        err_reg      <= err_next;
        out_byte_reg <= out_byte_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    // the dividend comes straight from the accepted read item, the divisor from the cluster size
    fcr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (read_position),
        .divisor  (cs_init),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    fcr_store #(
        .LINK_ENTRIES (LINK_ENTRIES),
        .DATA_BYTES   (DATA_BYTES)
    ) u_store (
        .aclk       (aclk),
        .req        (mem_req),
        .link_rdata (link_rdata),
        .data_rdata (data_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_err_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("result register overwritten");
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0]))
        else $error("error result not final");
    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide");
    a_hops_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOP && hops_reg == '0) |=> (state_reg == ST_ADDR))
        else $error("walk did not finish");

endmodule
